// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the detection row decoder RTL.
// No dependencies; the checks compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

// ----- hw/rtl/drw_pkg.sv -----
// Shared constants, register codes and types of the detection row decoder.
// No dependencies; used by the interfaces and every module.
package drw_pkg;

   localparam int VALUE_BITS  = 16;
   localparam int MAX_CLASSES = 128;
   localparam int BOX_ELEMS   = 4;
   localparam int CLASS_BASE  = 5;
   localparam int FRAC_BITS   = VALUE_BITS - 1;

   localparam int POS_BITS     = $clog2(BOX_ELEMS + MAX_CLASSES + 1);
   localparam int BOX_IDX_BITS = $clog2(BOX_ELEMS);

   localparam int THR_BITS   = 16;
   localparam int DIM_BITS   = 14;
   localparam int COUNT_BITS = 8;
   localparam int CLASS_BITS = 7;
   localparam int SCORE_BITS = 16;
   localparam int COORD_BITS = 16;
   localparam int SIZE_BITS  = 15;

   localparam int PROD_BITS = VALUE_BITS + DIM_BITS;
   localparam int DIFF_BITS = PROD_BITS + 2;

   localparam int CSR_IDX_BITS  = 8;
   localparam int CSR_DATA_BITS = 16;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [THR_BITS-1:0]   THRESHOLD_RESET   = THR_BITS'(16384);
   localparam logic [DIM_BITS-1:0]   IMAGE_WIDTH_RESET = DIM_BITS'(640);
   localparam logic [DIM_BITS-1:0]   IMAGE_HEIGHT_RESET = DIM_BITS'(640);
   localparam logic [COUNT_BITS-1:0] CLASS_COUNT_RESET = COUNT_BITS'(80);

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_SCORE_THRESHOLD = 8'd0,
      CSR_IMAGE_WIDTH     = 8'd1,
      CSR_IMAGE_HEIGHT    = 8'd2,
      CSR_CLASS_COUNT     = 8'd3
   } csr_index_type;

   // one finished row that passed the threshold, waiting for box math
   typedef struct packed {
      logic [CLASS_BITS-1:0] class_index;
      logic [SCORE_BITS-1:0] score;
      logic [VALUE_BITS-1:0] cx;
      logic [VALUE_BITS-1:0] cy;
      logic [VALUE_BITS-1:0] bw;
      logic [VALUE_BITS-1:0] bh;
      logic [DIM_BITS-1:0]   img_w;
      logic [DIM_BITS-1:0]   img_h;
   } job_type;

endpackage

// ----- hw/rtl/drw_if.sv -----
// Valid/ready channel interfaces: row values in, detections out, register writes.
// Depends on drw_pkg.
interface drw_req_if;
   import drw_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] value;
   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

interface drw_rsp_if;
   import drw_pkg::*;
   logic                         valid;
   logic                         ready;
   logic [CLASS_BITS-1:0]        class_index;
   logic [SCORE_BITS-1:0]        score;
   logic signed [COORD_BITS-1:0] left;
   logic signed [COORD_BITS-1:0] top;
   logic [SIZE_BITS-1:0]         box_width;
   logic [SIZE_BITS-1:0]         box_height;
   modport source (output valid, output class_index, output score, output left,
                   output top, output box_width, output box_height, input ready);
   modport sink (input valid, input class_index, input score, input left,
                 input top, input box_width, input box_height, output ready);
endinterface

interface drw_csr_if;
   import drw_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [CSR_IDX_BITS-1:0]  index;
   logic [CSR_DATA_BITS-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/drw_front.sv -----
// Front end: register file, row position tracking, box capture, class argmax.
// Depends on drw_pkg and drw_if; pushes finished rows into drw_queue.
`include "assert_macros.svh"
module drw_front (
   input  logic              clock,
   input  logic              reset,
   drw_req_if.sink           req_ch,
   drw_csr_if.sink           csr_ch,
   input  logic              q_ready,
   output logic              q_push,
   output drw_pkg::job_type  q_job
);
   import drw_pkg::*;

   logic [THR_BITS-1:0]   thr_ff, thr_in;
   logic [DIM_BITS-1:0]   img_w_ff, img_w_in;
   logic [DIM_BITS-1:0]   img_h_ff, img_h_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   logic [POS_BITS-1:0]   pos_ff, pos_in;
   logic [VALUE_BITS-1:0] box_ff [BOX_ELEMS];
   logic [VALUE_BITS-1:0] box_in [BOX_ELEMS];
   logic [VALUE_BITS-1:0] obj_ff, obj_in;
   logic [CLASS_BITS-1:0] best_class_ff, best_class_in;
   logic [VALUE_BITS-1:0] best_score_ff, best_score_in;

   logic [POS_BITS-1:0]   n_classes;
   logic [POS_BITS:0]     last_pos;
   logic                  row_end;
   logic                  accept;

   assign req_ch.ready = q_ready;
   assign csr_ch.ready = 1'b1;
   assign accept = req_ch.valid && q_ready;

   always_comb begin
      thr_in   = thr_ff;
      img_w_in = img_w_ff;
      img_h_in = img_h_ff;
      count_in = count_ff;
      if (csr_ch.valid) begin
         case (csr_index_type'(csr_ch.index))
            CSR_SCORE_THRESHOLD: thr_in = csr_ch.data[THR_BITS-1:0];
            CSR_IMAGE_WIDTH:     img_w_in = csr_ch.data[DIM_BITS-1:0];
            CSR_IMAGE_HEIGHT:    img_h_in = csr_ch.data[DIM_BITS-1:0];
            CSR_CLASS_COUNT:     count_in = csr_ch.data[COUNT_BITS-1:0];
            default:             thr_in = thr_ff;
         endcase
      end
   end

   always_comb begin
      if (int'(count_ff) > MAX_CLASSES) begin
         n_classes = POS_BITS'(MAX_CLASSES);
      end else begin
         n_classes = POS_BITS'(count_ff);
      end
      last_pos = (POS_BITS+1)'(BOX_ELEMS) + {1'b0, n_classes};
      // a lowered class count can leave the position past the last element
      row_end  = {1'b0, pos_ff} >= last_pos;

      box_in        = box_ff;
      obj_in        = obj_ff;
      best_class_in = best_class_ff;
      best_score_in = best_score_ff;
      if (int'(pos_ff) < BOX_ELEMS) begin
         box_in[pos_ff[BOX_IDX_BITS-1:0]] = req_ch.value;
      end else if (int'(pos_ff) == BOX_ELEMS) begin
         obj_in        = req_ch.value;
         best_class_in = '0;
         best_score_in = '0;
      end else if (req_ch.value >= best_score_ff) begin
         // ties go to the later class
         best_score_in = req_ch.value;
         best_class_in = CLASS_BITS'(pos_ff - POS_BITS'(CLASS_BASE));
      end
      pos_in = row_end ? '0 : pos_ff + POS_BITS'(1);

      q_job.class_index = (n_classes == '0) ? '0 : best_class_in;
      q_job.score       = SCORE_BITS'(obj_in);
      q_job.cx          = box_in[0];
      q_job.cy          = box_in[1];
      q_job.bw          = box_in[2];
      q_job.bh          = box_in[3];
      q_job.img_w       = img_w_ff;
      q_job.img_h       = img_h_ff;
      q_push = accept && row_end && (obj_in > VALUE_BITS'(thr_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= THRESHOLD_RESET;
         img_w_ff <= IMAGE_WIDTH_RESET;
         img_h_ff <= IMAGE_HEIGHT_RESET;
         count_ff <= CLASS_COUNT_RESET;
         pos_ff   <= '0;
      end else begin
         thr_ff   <= thr_in;
         img_w_ff <= img_w_in;
         img_h_ff <= img_h_in;
         count_ff <= count_in;
         if (accept) begin
            pos_ff <= pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         box_ff        <= box_in;
         obj_ff        <= obj_in;
         best_class_ff <= best_class_in;
         best_score_ff <= best_score_in;
      end
   end

   `ASSERT_PROP(pos_in_range, clock, reset,
                int'(pos_ff) <= BOX_ELEMS + MAX_CLASSES)
   `ASSERT_PROP(push_only_at_row_end, clock, reset, q_push |-> accept && row_end)

endmodule

// ----- hw/rtl/drw_queue.sv -----
// Short FIFO of finished rows between the front end and the box math.
// Depends on drw_pkg.
`include "assert_macros.svh"
module drw_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  drw_pkg::job_type  push_job,
   output logic              not_full,
   input  logic              pop,
   output logic              not_empty,
   output drw_pkg::job_type  head_job
);
   import drw_pkg::*;

   job_type              mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;
   logic                 do_push, do_pop;

   function automatic logic [QPTR_BITS-1:0] next_ptr(input logic [QPTR_BITS-1:0] p);
      logic [QPTR_BITS-1:0] r;
      if (int'(p) == QUEUE_DEPTH - 1) begin
         r = '0;
      end else begin
         r = p + QPTR_BITS'(1);
      end
      return r;
   endfunction

   assign not_full  = int'(count_ff) < QUEUE_DEPTH;
   assign not_empty = count_ff != '0;
   assign head_job  = mem_ff[rd_ptr_ff];
   assign do_push   = push && not_full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   `ASSERT_NEVER(no_push_when_full, clock, reset, push && !not_full)
   `ASSERT_NEVER(no_pop_when_empty, clock, reset, pop && !not_empty)
   `ASSERT_PROP(count_bounded, clock, reset, int'(count_ff) <= QUEUE_DEPTH)

endmodule

// ----- hw/rtl/drw_back.sv -----
// Back end: scales a detection to pixels and converts centre form to corners.
// Depends on drw_pkg and drw_if; takes jobs from drw_queue.
`include "assert_macros.svh"
module drw_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  drw_pkg::job_type  q_job,
   output logic              q_pop,
   drw_rsp_if.source         rsp_ch
);
   import drw_pkg::*;

   // stage 1: products
   logic                  s1_valid_ff;
   logic [PROD_BITS-1:0]  px_ff, py_ff, pw_ff, ph_ff;
   logic [CLASS_BITS-1:0] s1_class_ff;
   logic [SCORE_BITS-1:0] s1_score_ff;
   logic                  s1_ready;

   // stage 2: output word
   logic                         out_valid_ff;
   logic [CLASS_BITS-1:0]        out_class_ff;
   logic [SCORE_BITS-1:0]        out_score_ff;
   logic signed [COORD_BITS-1:0] out_left_ff, out_left_in;
   logic signed [COORD_BITS-1:0] out_top_ff, out_top_in;
   logic [SIZE_BITS-1:0]         out_w_ff, out_w_in;
   logic [SIZE_BITS-1:0]         out_h_ff, out_h_in;
   logic                         out_ready;

   logic signed [DIFF_BITS-1:0] dx, dy, dxb, dyb, sx, sy;
   logic [PROD_BITS-1:0]        sw, sh;

   localparam logic [DIFF_BITS-1:0] ROUND_BIAS = DIFF_BITS'((1 << (FRAC_BITS + 1)) - 1);

   assign out_ready = !out_valid_ff || rsp_ch.ready;
   assign s1_ready  = !s1_valid_ff || out_ready;
   assign q_pop     = q_valid && s1_ready;

   always_comb begin
      dx = $signed({1'b0, px_ff, 1'b0}) - $signed({2'b00, pw_ff});
      dy = $signed({1'b0, py_ff, 1'b0}) - $signed({2'b00, ph_ff});
      // bias negatives so the arithmetic shift truncates toward zero
      dxb = $signed(dx + (dx[DIFF_BITS-1] ? ROUND_BIAS : '0));
      dyb = $signed(dy + (dy[DIFF_BITS-1] ? ROUND_BIAS : '0));
      sx  = dxb >>> (FRAC_BITS + 1);
      sy  = dyb >>> (FRAC_BITS + 1);
      sw  = pw_ff >> FRAC_BITS;
      sh  = ph_ff >> FRAC_BITS;
      out_left_in = sx[COORD_BITS-1:0];
      out_top_in  = sy[COORD_BITS-1:0];
      out_w_in    = sw[SIZE_BITS-1:0];
      out_h_in    = sh[SIZE_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= q_valid;
         end
         if (out_ready) begin
            out_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         px_ff       <= PROD_BITS'(q_job.cx * q_job.img_w);
         py_ff       <= PROD_BITS'(q_job.cy * q_job.img_h);
         pw_ff       <= PROD_BITS'(q_job.bw * q_job.img_w);
         ph_ff       <= PROD_BITS'(q_job.bh * q_job.img_h);
         s1_class_ff <= q_job.class_index;
         s1_score_ff <= q_job.score;
      end
      if (out_ready && s1_valid_ff) begin
         out_class_ff <= s1_class_ff;
         out_score_ff <= s1_score_ff;
         out_left_ff  <= out_left_in;
         out_top_ff   <= out_top_in;
         out_w_ff     <= out_w_in;
         out_h_ff     <= out_h_in;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.class_index = out_class_ff;
   assign rsp_ch.score       = out_score_ff;
   assign rsp_ch.left        = out_left_ff;
   assign rsp_ch.top         = out_top_ff;
   assign rsp_ch.box_width   = out_w_ff;
   assign rsp_ch.box_height  = out_h_ff;

   `ASSERT_PROP(s1_holds_when_blocked, clock, reset,
                s1_valid_ff && !out_ready |=> s1_valid_ff)
   `ASSERT_PROP(pop_lands_in_s1, clock, reset, q_pop |=> s1_valid_ff)

endmodule

// ----- hw/rtl/detection_row_decoder.sv -----
// Top level of the detection row decoder: front end, row queue, box math.
// Depends on drw_pkg, drw_if, drw_front, drw_queue and drw_back.
//
// Usage:
//   req_ch carries row values one word per cycle: centre x, centre y, width,
//   height, objectness, then class_count class scores (Q1.15, unsigned).
//   The row position is tracked inside; there is no framing signal.
//   rsp_ch carries one detection word per row whose objectness is above
//   score_threshold: best class (ties to the later class), objectness and
//   the box in pixels as left, top, width, height, truncated toward zero.
//   csr_ch writes score_threshold (0), image_width (1), image_height (2)
//   and class_count (3); it is always ready, other indexes are dropped.
// Throughput: one value per cycle while not stalled; the per-row box math
//   runs in a two-stage pipeline fed from a two-entry row queue.
// Path: a finished row goes into the row queue, then to the multiply stage
//   and then to the output register that drives rsp_ch.
// Reset: registers return to their defaults, the row position goes to the
//   first element and queue and pipeline are emptied.
// Stall: when rsp_ch is not ready, the pipeline and queue hold up to four
//   pending detections; req_ch.ready drops only once the queue is full.
module detection_row_decoder (
   input  logic    clock,
   input  logic    reset,
   drw_req_if.sink   req_ch,
   drw_rsp_if.source rsp_ch,
   drw_csr_if.sink   csr_ch
);
   import drw_pkg::*;

   logic    q_push, q_not_full, q_pop, q_not_empty;
   job_type push_job, head_job;

   drw_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .csr_ch  (csr_ch),
      .q_ready (q_not_full),
      .q_push  (q_push),
      .q_job   (push_job)
   );

   drw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_job  (push_job),
      .not_full  (q_not_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_job  (head_job)
   );

   drw_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_not_empty),
      .q_job   (head_job),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

endmodule
